// ----- sv/color_cycling_line_rasterizer_top_macros.svh -----
// Assertion helpers shared by the rasterizer modules.
// Each expects aclk and aresetn in the scope where it is used.
`ifndef COLOR_CYCLING_LINE_RASTERIZER_TOP_MACROS_SVH
`define COLOR_CYCLING_LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication.
`define CCL_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CCL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ccl_pkg.sv -----
package ccl_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 4;

    localparam logic [COLOR_BITS-1:0] COLOR_MIN = 4'd1;
    localparam logic [COLOR_BITS-1:0] COLOR_MAX = 4'd15;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    // Control of the item held in the input register.
    typedef struct packed {
        logic  valid;
        func_t func;
    } ccl_item_ctl_t;

    // Control of a result handed to the output register.
    typedef struct packed {
        logic push;
        logic last;
    } ccl_res_ctl_t;

endpackage

// ----- sv/ccl_in_stage.sv -----
module ccl_in_stage import ccl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  func_t                 in_func,
    input  logic [COORD_BITS-1:0] in_x_start,
    input  logic [COORD_BITS-1:0] in_y_start,
    input  logic [COORD_BITS-1:0] in_x_end,
    input  logic [COORD_BITS-1:0] in_y_end,
    input  logic                  take,
    output ccl_item_ctl_t         item_ctl,
    output logic [COORD_BITS-1:0] item_x_start,
    output logic [COORD_BITS-1:0] item_y_start,
    output logic [COORD_BITS-1:0] item_x_end,
    output logic [COORD_BITS-1:0] item_y_end
);

    logic                  valid_reg, valid_next;
    func_t                 func_reg;
    logic [COORD_BITS-1:0] x_start_reg, y_start_reg, x_end_reg, y_end_reg;
    logic                  load;

    // Refill in the same cycle the held item is consumed.
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            func_reg    <= in_func;
            x_start_reg <= in_x_start;
            y_start_reg <= in_y_start;
            x_end_reg   <= in_x_end;
            y_end_reg   <= in_y_end;
        end
    end

    assign item_ctl.valid = valid_reg;
    assign item_ctl.func  = func_reg;
    assign item_x_start   = x_start_reg;
    assign item_y_start   = y_start_reg;
    assign item_x_end     = x_end_reg;
    assign item_y_end     = y_end_reg;

endmodule

// ----- sv/ccl_step_core.sv -----
`include "color_cycling_line_rasterizer_top_macros.svh"

module ccl_step_core import ccl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ccl_item_ctl_t         item_ctl,
    input  logic [COORD_BITS-1:0] item_x_start,
    input  logic [COORD_BITS-1:0] item_y_start,
    input  logic [COORD_BITS-1:0] item_x_end,
    input  logic [COORD_BITS-1:0] item_y_end,
    input  logic                  out_free,
    output logic                  take,
    output ccl_res_ctl_t          res_ctl,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic [COLOR_BITS-1:0] res_color
);

    localparam int DEC_BITS = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [DEC_BITS-1:0]   decision_reg, decision_next;
    logic [COORD_BITS-1:0] delta_major_reg, delta_major_next;
    logic [COORD_BITS-1:0] delta_minor_reg, delta_minor_next;
    logic                  x_dir_neg_reg, x_dir_neg_next;
    logic                  y_dir_neg_reg, y_dir_neg_next;
    logic                  x_is_major_reg, x_is_major_next;
    logic [COORD_BITS-1:0] remaining_reg, remaining_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;

    // Start-side terms
    logic                  x_up, y_up;
    logic [COORD_BITS-1:0] dx, dy, s_major, s_minor;
    logic                  s_x_major;

    // Step-side terms
    logic [COORD_BITS-1:0] x_moved, y_moved, rem_dec;
    logic                  minor_move;

    assign take = item_ctl.valid && out_free;

    always_comb begin
        x_up      = item_x_end > item_x_start;
        y_up      = item_y_end > item_y_start;
        dx        = x_up ? item_x_end - item_x_start : item_x_start - item_x_end;
        dy        = y_up ? item_y_end - item_y_start : item_y_start - item_y_end;
        s_x_major = dx > dy;
        s_major   = s_x_major ? dx : dy;
        s_minor   = s_x_major ? dy : dx;

        x_moved    = x_dir_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        y_moved    = y_dir_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        minor_move = !decision_reg[DEC_BITS-1];
        rem_dec    = remaining_reg - 1'b1;
    end

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        decision_next    = decision_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        x_dir_neg_next   = x_dir_neg_reg;
        y_dir_neg_next   = y_dir_neg_reg;
        x_is_major_next  = x_is_major_reg;
        remaining_next   = remaining_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        res_ctl.push     = 1'b0;
        res_ctl.last     = 1'b0;

        if (take) begin
            unique case (item_ctl.func)
                FUNC_START: begin
                    // Load the line and emit its first endpoint.
                    cur_x_next       = item_x_start;
                    cur_y_next       = item_y_start;
                    x_dir_neg_next   = !x_up;
                    y_dir_neg_next   = !y_up;
                    x_is_major_next  = s_x_major;
                    delta_major_next = s_major;
                    delta_minor_next = s_minor;
                    decision_next    = {1'b0, s_minor, 1'b0} - {2'b00, s_major};
                    remaining_next   = s_major;
                    color_next       = COLOR_MIN;
                    active_next      = s_major != '0;
                    res_ctl.push     = 1'b1;
                    res_ctl.last     = s_major == '0;
                end
                FUNC_STEP: begin
                    // Idle steps drop without a result.
                    if (active_reg) begin
                        if (x_is_major_reg) begin
                            cur_x_next = x_moved;
                            if (minor_move) begin
                                cur_y_next = y_moved;
                            end
                        end else begin
                            cur_y_next = y_moved;
                            if (minor_move) begin
                                cur_x_next = x_moved;
                            end
                        end
                        if (minor_move) begin
                            decision_next = decision_reg
                                + {1'b0, delta_minor_reg, 1'b0}
                                - {1'b0, delta_major_reg, 1'b0};
                        end else begin
                            decision_next = decision_reg + {1'b0, delta_minor_reg, 1'b0};
                        end
                        color_next     = (color_reg >= COLOR_MAX) ? COLOR_MIN
                                                                  : color_reg + 1'b1;
                        remaining_next = rem_dec;
                        active_next    = rem_dec != '0;
                        res_ctl.push   = 1'b1;
                        res_ctl.last   = rem_dec == '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            decision_reg    <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            x_dir_neg_reg   <= 1'b0;
            y_dir_neg_reg   <= 1'b0;
            x_is_major_reg  <= 1'b0;
            remaining_reg   <= '0;
            active_reg      <= 1'b0;
            color_reg       <= COLOR_MIN;
        end else begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            decision_reg    <= decision_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            x_dir_neg_reg   <= x_dir_neg_next;
            y_dir_neg_reg   <= y_dir_neg_next;
            x_is_major_reg  <= x_is_major_next;
            remaining_reg   <= remaining_next;
            active_reg      <= active_next;
            color_reg       <= color_next;
        end
    end

    // Results carry the updated pixel and color.
    assign res_x     = cur_x_next;
    assign res_y     = cur_y_next;
    assign res_color = color_next;

    `CCL_CHECK_NOW(a_color_range, 1'b1, color_reg != '0 && color_reg <= COLOR_MAX, "color out of range")
    `CCL_CHECK_NOW(a_active_count, active_reg, remaining_reg != '0, "active line with no steps left")
    `CCL_CHECK_NEXT(a_last_ends_line, res_ctl.push && res_ctl.last, !active_reg, "line still active after last pixel")
    `CCL_CHECK_NEXT(a_idle_step_hold, take && item_ctl.func == FUNC_STEP && !active_reg, $stable(cur_x_reg) && $stable(cur_y_reg) && !active_reg, "idle step changed state")

endmodule

// ----- sv/ccl_out_stage.sv -----
`include "color_cycling_line_rasterizer_top_macros.svh"

module ccl_out_stage import ccl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ccl_res_ctl_t          res_ctl,
    input  logic [COORD_BITS-1:0] res_x,
    input  logic [COORD_BITS-1:0] res_y,
    input  logic [COLOR_BITS-1:0] res_color,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic [COLOR_BITS-1:0] out_color,
    output logic                  out_last
);

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  last_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ctl.push) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ctl.push) begin
            x_reg     <= res_x;
            y_reg     <= res_y;
            color_reg <= res_color;
            last_reg  <= res_ctl.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_color = color_reg;
    assign out_last  = last_reg;

    `CCL_CHECK_NOW(a_no_overwrite, res_ctl.push, !valid_reg || out_ready, "result overwrites a pending transaction")

endmodule

// ----- sv/color_cycling_line_rasterizer_top.sv -----
// Channel  Direction  Fields (low bit first)
// s_       in         tuser: func; tdata: x_start, y_start, x_end, y_end
// m_       out        tdata: pixel_x, pixel_y, pixel_color; tlast: last
//
// One transaction per clock sustained while m_tready stays high: each input
// passes an input register, one Bresenham add/compare of the state registers,
// then the result register. The step loop closes through the state registers.
// aresetn is synchronous and active low; it clears both stage valids and the
// line-active flag.
// m_tready low holds the result register and stalls the input register;
// s_tready stays high while the input register is empty or draining.
module color_cycling_line_rasterizer_top import ccl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end, zero pad
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
    output logic                 m_tlast
);

    ccl_item_ctl_t         item_ctl;
    ccl_res_ctl_t          res_ctl;
    logic [COORD_BITS-1:0] item_x_start, item_y_start, item_x_end, item_y_end;
    logic [COORD_BITS-1:0] res_x, res_y, out_x, out_y;
    logic [COLOR_BITS-1:0] res_color, out_color;
    logic                  take, out_free;

    // Capture the incoming transaction.
    ccl_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (func_t'(s_tuser)),
        .in_x_start   (s_tdata[COORD_BITS-1:0]),
        .in_y_start   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_x_end     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_y_end     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .take         (take),
        .item_ctl     (item_ctl),
        .item_x_start (item_x_start),
        .item_y_start (item_y_start),
        .item_x_end   (item_x_end),
        .item_y_end   (item_y_end)
    );

    // Advance the line state by one pixel or load a new line.
    ccl_step_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_ctl     (item_ctl),
        .item_x_start (item_x_start),
        .item_y_start (item_y_start),
        .item_x_end   (item_x_end),
        .item_y_end   (item_y_end),
        .out_free     (out_free),
        .take         (take),
        .res_ctl      (res_ctl),
        .res_x        (res_x),
        .res_y        (res_y),
        .res_color    (res_color)
    );

    // Hold the pixel until the downstream side takes it.
    ccl_out_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_ctl   (res_ctl),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_color (res_color),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({out_color, out_y, out_x});

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import ccl_pkg::*;

    localparam int            CB              = COORD_BITS_DEF;
    localparam int            COORD_MAX       = (1 << CB) - 1;
    localparam logic [CB-1:0] C_TOP           = '1;
    localparam int            S_W             = ((4 * CB + 7) / 8) * 8;
    localparam int            M_W             = ((2 * CB + COLOR_BITS + 7) / 8) * 8;
    localparam int            N_ITEMS         = 1350;
    localparam int            LONG_HOLD       = 300;
    localparam int            WATCHDOG_CYCLES = 2000;
    localparam int            DRAIN_CYCLES    = 8;

    // One queued command toward the rasterizer; drain makes the sender wait
    // until every predicted pixel has come out before offering it.
    typedef struct {
        func_t         func;
        logic [CB-1:0] x0, y0, x1, y1;
        bit            drain;
    } draw_cmd_t;

    typedef struct packed {
        logic [CB-1:0]         px;
        logic [CB-1:0]         py;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    logic           aclk;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;    // x_start, y_start, x_end, y_end, zero pad
    logic           s_tuser  = 1'b0;  // func
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;          // pixel_x, pixel_y, pixel_color, zero pad
    logic           m_tlast;

    color_cycling_line_rasterizer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    draw_cmd_t draw_cmds[$];
    pixel_t    expected_pixels[$];

    // Shadow of the line engine, advanced once per accepted input transaction.
    logic [CB-1:0]         px, py;
    logic signed [CB+1:0]  err        = '0;
    logic [CB-1:0]         d_major    = '0;
    logic [CB-1:0]         d_minor    = '0;
    logic                  x_neg      = 1'b0;
    logic                  y_neg      = 1'b0;
    logic                  x_major    = 1'b0;
    logic [CB-1:0]         steps_left = '0;
    logic [COLOR_BITS-1:0] color      = COLOR_MIN;
    logic                  line_on    = 1'b0;

    bit        s_xfer, m_xfer;
    int        cmds_total;
    int        cmds_taken   = 0;
    int        pixels_taken = 0;
    int        mismatches   = 0;
    int        idle_cycles  = 0;
    int        tx_gap       = 0;
    int        rx_wait      = 0;
    bit        tx_burst     = 0;
    bit        rx_burst     = 0;
    draw_cmd_t tx_cmd;

    wire wd_expired = idle_cycles >= WATCHDOG_CYCLES;

    initial begin
        px = '0;
        py = '0;
    end

    function automatic logic [CB-1:0] step_coord(logic [CB-1:0] c, logic neg);
        return neg ? c - 1'b1 : c + 1'b1;
    endfunction

    // Work out the pixel (if any) that one input transaction produces.
    task automatic trace_line(func_t op, logic [S_W-1:0] d);
        logic [CB-1:0] xa, ya, xb, yb, dx, dy;
        if (op == FUNC_START) begin
            xa = d[CB-1:0];
            ya = d[2*CB-1:CB];
            xb = d[3*CB-1:2*CB];
            yb = d[4*CB-1:3*CB];
            dx = (xb > xa) ? xb - xa : xa - xb;
            dy = (yb > ya) ? yb - ya : ya - yb;
            // An axis with equal ends counts as decreasing; its delta is zero anyway.
            x_neg      = !(xb > xa);
            y_neg      = !(yb > ya);
            x_major    = dx > dy;   // a tie goes to y
            d_major    = x_major ? dx : dy;
            d_minor    = x_major ? dy : dx;
            err        = 2 * d_minor - d_major;
            px         = xa;
            py         = ya;
            steps_left = d_major;
            color      = COLOR_MIN;
            line_on    = steps_left != '0;
        end else if (line_on) begin
            if (x_major) px = step_coord(px, x_neg);
            else         py = step_coord(py, y_neg);
            if (err < 0) begin
                err = err + 2 * d_minor;
            end else begin
                if (x_major) py = step_coord(py, y_neg);
                else         px = step_coord(px, x_neg);
                err = err + 2 * (d_minor - d_major);
            end
            color      = (color >= COLOR_MAX) ? COLOR_MIN : color + 1'b1;
            steps_left = steps_left - 1'b1;
            if (steps_left == '0) line_on = 1'b0;
        end else begin
            return;  // step with no line in progress: nothing comes out
        end
        expected_pixels.push_back('{px, py, color, !line_on});
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels at the rising edge: check results, then predict.
    always @(posedge aclk) begin
        pixel_t want;
        s_xfer = aresetn && s_tvalid && s_tready;
        m_xfer = aresetn && m_tvalid && m_tready;
        if (m_xfer) begin
            pixels_taken++;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d color=%0d last=%0b",
                         $time, m_tdata[CB-1:0], m_tdata[2*CB-1:CB],
                         m_tdata[2*CB+COLOR_BITS-1:2*CB], m_tlast);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", want.px, m_tdata[CB-1:0]);
                check_field("pixel_y", want.py, m_tdata[2*CB-1:CB]);
                check_field("pixel_color", want.color, m_tdata[2*CB+COLOR_BITS-1:2*CB]);
                check_field("last", want.last, m_tlast);
            end
        end
        if (s_xfer) begin
            trace_line(func_t'(s_tuser), s_tdata);
            cmds_taken++;
        end
        idle_cycles = (s_xfer || m_xfer) ? 0 : idle_cycles + 1;
    end

    // Sender: hold the offered transaction until taken, then wait a drawn gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_xfer) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (draw_cmds.size() != 0 &&
                         !(draw_cmds[0].drain && expected_pixels.size() != 0)) begin
                tx_cmd = draw_cmds.pop_front();
                s_tuser  <= tx_cmd.func;
                s_tdata  <= S_W'({tx_cmd.y1, tx_cmd.x1, tx_cmd.y0, tx_cmd.x0});
                s_tvalid <= 1'b1;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: drop tready for a drawn number of cycles after each result;
    // twice hold off long enough that the block backs up into its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_xfer) begin
                if (pixels_taken == 120 || pixels_taken == 700) rx_wait = LONG_HOLD;
                else rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            end
            if (rx_wait != 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [CB-1:0] rnd_coord();
        return CB'($urandom);
    endfunction

    function automatic logic [CB-1:0] near(logic [CB-1:0] c, int reach);
        int lo, hi;
        lo = (int'(c) > reach) ? int'(c) - reach : 0;
        hi = (int'(c) + reach > COORD_MAX) ? COORD_MAX : int'(c) + reach;
        return CB'($urandom_range(hi, lo));
    endfunction

    function automatic int span(logic [CB-1:0] a, logic [CB-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    task automatic queue_cmd(func_t f, logic [CB-1:0] xa, logic [CB-1:0] ya,
                             logic [CB-1:0] xb, logic [CB-1:0] yb, bit drain);
        draw_cmds.push_back('{f, xa, ya, xb, yb, drain});
    endtask

    // Start a line, then advance it n times; step transactions carry junk coordinates.
    task automatic queue_line(logic [CB-1:0] xa, logic [CB-1:0] ya,
                              logic [CB-1:0] xb, logic [CB-1:0] yb, int n, bit drain);
        queue_cmd(FUNC_START, xa, ya, xb, yb, drain);
        repeat (n) queue_cmd(FUNC_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 0);
    endtask

    initial begin
        logic [CB-1:0] xa, ya, xb, yb;
        int            kind, major, n, d;
        bit            drain;

        // Directed: idle steps, a zero-length line, an axis with equal ends,
        // each direction, ties, and a start that abandons a line in progress.
        queue_cmd(FUNC_STEP, C_TOP, C_TOP, C_TOP, C_TOP, 0);
        queue_line(0, 0, 0, 0, 1, 0);
        queue_line(C_TOP, 0, C_TOP, 3, 4, 0);
        queue_line(5, 5, 0, 7, 5, 1);
        queue_line(C_TOP, C_TOP, 0, 0, 3, 0);
        queue_line(0, C_TOP, 3, C_TOP - 3'd3, 3, 0);
        queue_line(C_TOP, 512, 0, 513, 2, 0);

        // One long line to wrap the color several times.
        xa = CB'($urandom_range(0, 400));
        ya = rnd_coord();
        xb = xa + CB'($urandom_range(100, 150));
        yb = near(ya, 60);
        queue_line(xa, ya, xb, yb, span(xa, xb), 0);

        // Mostly complete short lines; the rest abandoned, far-flung, odd shapes or noise.
        while (draw_cmds.size() < N_ITEMS) begin
            kind  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 49) == 0);
            xa = rnd_coord();
            ya = rnd_coord();
            if (kind < 75) begin
                xb = near(xa, 40);
                yb = near(ya, 40);
                major = (span(xa, xb) > span(ya, yb)) ? span(xa, xb) : span(ya, yb);
                if (kind < 60)
                    n = major + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
                else
                    n = (major == 0) ? 0 : $urandom_range(0, major - 1);
                queue_line(xa, ya, xb, yb, n, drain);
            end else if (kind < 85) begin
                queue_line(xa, ya, rnd_coord(), rnd_coord(), $urandom_range(0, 30), drain);
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(func_t'($urandom_range(0, 1)), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), 0);
            end else begin
                d  = $urandom_range(0, 25);
                xa = CB'($urandom_range(25, COORD_MAX - 25));
                ya = CB'($urandom_range(25, COORD_MAX - 25));
                xb = $urandom_range(0, 1) ? xa + CB'(d) : xa - CB'(d);
                yb = $urandom_range(0, 1) ? ya + CB'(d) : ya - CB'(d);
                case ($urandom_range(0, 2))
                    1: xb = xa;
                    2: yb = ya;
                    default: ;
                endcase
                queue_line(xa, ya, xb, yb, d, drain);
            end
        end
        cmds_total = draw_cmds.size();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken != cmds_total && !wd_expired) @(negedge aclk);
        while (expected_pixels.size() != 0 && !wd_expired) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && !wd_expired) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- color_cycling_line_rasterizer_top.f -----
+incdir+sv
sv/ccl_pkg.sv
sv/ccl_in_stage.sv
sv/ccl_step_core.sv
sv/ccl_out_stage.sv
sv/color_cycling_line_rasterizer_top.sv
bench/tb_top.sv
